// File: sv/cv2_pkg.sv
// Shared constants and types for the 2D convolution / ReLU block.
package cv2_pkg;

  localparam int DEF_MAX_WIDTH    = 64;
  localparam int DEF_MAX_KERNEL   = 5;
  localparam int DEF_MAX_FILTERS  = 8;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int HEIGHT_LIMIT     = 64;

  localparam int VAL_W  = 16;
  localparam int OUT_W  = 15;
  localparam int FRAC_W = 12;

  // input action codes (tuser)
  localparam logic [1:0] ACT_COEF  = 2'd0;
  localparam logic [1:0] ACT_BIAS  = 2'd1;
  localparam logic [1:0] ACT_IMAGE = 2'd2;
  localparam logic [1:0] ACT_SOF   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_KERNEL   = 3'd2;
  localparam logic [2:0] REG_FILTERS  = 3'd3;
  localparam logic [2:0] REG_CHANNELS = 3'd4;

  localparam logic [6:0] RST_WIDTH    = 7'd32;
  localparam logic [6:0] RST_HEIGHT   = 7'd32;
  localparam logic [2:0] RST_KERNEL   = 3'd3;
  localparam logic [3:0] RST_FILTERS  = 4'd8;
  localparam logic [2:0] RST_CHANNELS = 3'd3;

  // control that travels with each tap along the cell chain
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } cv2_ctl_t;

endpackage

// File: sv/conv2d_valid_relu_top.sv
// Top level: line store, window sequencer, filter cell chain and result register.
//
//  channel  | dir | accepted when                 | payload
//  s_axis   | in  | s_axis_tvalid & s_axis_tready | tdata, tuser = action
//  m_axis   | out | m_axis_tvalid & m_axis_tready | tdata, tuser = saturated, tlast
//  cfg      | in  | cfg_valid_i & cfg_ready_o     | cfg_index_i, cfg_data_i
//
// Loads, start of frame and image values without a full window leave the input ready.
// A value that completes a window issues channels*k*k taps from the line store,
// one per cycle, into the filter chain; filter 0's result passes the feed, operand,
// product, accumulator and result registers into the output register, the others
// follow one per cycle while the output is free. Input is held off from that value
// until the last result is loaded; an output stall holds the result drain. Reset is asynchronous.
module conv2d_valid_relu_top #(
  parameter int MAX_WIDTH    = cv2_pkg::DEF_MAX_WIDTH,
  parameter int MAX_KERNEL   = cv2_pkg::DEF_MAX_KERNEL,
  parameter int MAX_FILTERS  = cv2_pkg::DEF_MAX_FILTERS,
  parameter int MAX_CHANNELS = cv2_pkg::DEF_MAX_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // filter_sel[2:0], channel_sel[4:3], kernel_row[7:5], kernel_col[10:8], value[26:11]
  input  logic [31:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_value[14:0], out_filter[17:15], out_row[23:18], out_col[29:24]
  output logic [31:0] m_axis_tdata,
  // saturated[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);
  import cv2_pkg::*;

  localparam int TAPS       = MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int TAP_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int LINE_DEPTH = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;
  localparam int LA_W       = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int SW         = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int KW         = $clog2(MAX_KERNEL + 1);
  localparam int QW         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCW        = $clog2(MAX_CHANNELS + 1);
  localparam int FW         = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int NFW        = $clog2(MAX_FILTERS + 1);
  localparam int ACC_W      = 33 + $clog2(TAPS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // fields
  logic [2:0]        in_fsel, in_krow, in_kcol;
  logic [1:0]        in_csel, in_act;
  logic signed [15:0] in_val;
  assign in_fsel = s_axis_tdata[2:0];
  assign in_csel = s_axis_tdata[4:3];
  assign in_krow = s_axis_tdata[7:5];
  assign in_kcol = s_axis_tdata[10:8];
  assign in_val  = s_axis_tdata[26:11];
  assign in_act  = s_axis_tuser;

  // configuration
  logic [6:0] width_q, height_q;
  logic [2:0] kernel_q, chans_q;
  logic [3:0] filt_q;
  logic       cfg_acc;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;

  logic [WW-1:0]  w_used;
  logic [6:0]     h_used;
  logic [KW-1:0]  k_used;
  logic [NFW-1:0] nf_used;
  logic [NCW-1:0] nc_used;

  always_comb begin
    if (width_q == '0) w_used = WW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_used = WW'(MAX_WIDTH);
    else w_used = WW'(width_q);
    if (height_q == '0) h_used = 7'd1;
    else if (32'(height_q) > HEIGHT_LIMIT) h_used = 7'(HEIGHT_LIMIT);
    else h_used = height_q;
    if (kernel_q == '0) k_used = KW'(1);
    else if (32'(kernel_q) > MAX_KERNEL) k_used = KW'(MAX_KERNEL);
    else k_used = KW'(kernel_q);
    if (filt_q == '0) nf_used = NFW'(1);
    else if (32'(filt_q) > MAX_FILTERS) nf_used = NFW'(MAX_FILTERS);
    else nf_used = NFW'(filt_q);
    if (chans_q == '0) nc_used = NCW'(1);
    else if (32'(chans_q) > MAX_CHANNELS) nc_used = NCW'(MAX_CHANNELS);
    else nc_used = NCW'(chans_q);
  end

  function automatic logic [LA_W-1:0] line_addr(input int slot, input int col, input int ch);
    line_addr = LA_W'((slot * MAX_WIDTH + col) * MAX_CHANNELS + ch);
  endfunction

  // state
  logic [1:0]      state_q;
  logic [5:0]      row_q;
  logic [CW-1:0]   col_q;
  logic [QW-1:0]   ch_q;
  logic [SW-1:0]   slot_q;
  logic [5:0]      orow_q;
  logic [CW-1:0]   ocol_q;
  logic [SW-1:0]   top_q, rslot_q;
  logic [QW-1:0]   q_q;
  logic [SW-1:0]   i_q, j_q;
  logic [FW-1:0]   oi_q;

  logic in_acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // current position, forced back to origin when out of range
  logic          out_rng;
  logic [5:0]    r_e;
  logic [CW-1:0] c_e;
  logic [QW-1:0] ch_e;
  logic [SW-1:0] slot_e;
  logic          fire;
  logic          img_acc;
  assign out_rng = (32'(row_q) >= 32'(h_used)) || (32'(col_q) >= 32'(w_used)) ||
                   (32'(ch_q) >= 32'(nc_used));
  assign r_e     = out_rng ? '0 : row_q;
  assign c_e     = out_rng ? '0 : col_q;
  assign ch_e    = out_rng ? '0 : ch_q;
  assign slot_e  = out_rng ? '0 : slot_q;
  assign img_acc = in_acc && (in_act == ACT_IMAGE);
  assign fire    = (32'(ch_e) + 1 == 32'(nc_used)) && (32'(r_e) + 1 >= 32'(k_used)) &&
                   (32'(c_e) + 1 >= 32'(k_used));

  // line store
  logic signed [15:0] line_mem [LINE_DEPTH];
  logic signed [15:0] line_rd_q;
  logic [LA_W-1:0]    wr_addr, rd_addr;
  assign wr_addr = line_addr(32'(slot_e), 32'(c_e), 32'(ch_e));
  assign rd_addr = line_addr(32'(rslot_q), 32'(ocol_q) + 32'(j_q), 32'(q_q));

  always_ff @(posedge clk_i) begin
    if (img_acc) begin
      line_mem[wr_addr] <= in_val;
    end
    line_rd_q <= line_mem[rd_addr];
  end

  // tap issue
  logic j_end, i_end, q_end;
  assign j_end = (32'(j_q) + 1 == 32'(k_used));
  assign i_end = (32'(i_q) + 1 == 32'(k_used));
  assign q_end = (32'(q_q) + 1 == 32'(nc_used));

  cv2_ctl_t         iss_ctl, feed_ctl_q;
  logic [TAP_W-1:0] iss_tap, feed_tap_q;
  assign iss_ctl.vld   = (state_q == ST_RUN);
  assign iss_ctl.first = (q_q == '0) && (i_q == '0) && (j_q == '0);
  assign iss_ctl.last  = q_end && i_end && j_end;
  assign iss_tap = TAP_W'((32'(q_q) * MAX_KERNEL + 32'(i_q)) * MAX_KERNEL + 32'(j_q));

  always_ff @(posedge clk_i) begin
    feed_tap_q <= iss_tap;
  end

  // load broadcast
  logic             ld_coef, ld_bias;
  logic [TAP_W-1:0] ld_tap;
  assign ld_coef = in_acc && (in_act == ACT_COEF) && (32'(in_fsel) < MAX_FILTERS) &&
                   (32'(in_csel) < MAX_CHANNELS) && (32'(in_krow) < MAX_KERNEL) &&
                   (32'(in_kcol) < MAX_KERNEL);
  assign ld_bias = in_acc && (in_act == ACT_BIAS) && (32'(in_fsel) < MAX_FILTERS);
  assign ld_tap  = TAP_W'((32'(in_csel) * MAX_KERNEL + 32'(in_krow)) * MAX_KERNEL +
                          32'(in_kcol));

  // cell chain
  cv2_ctl_t           ctl_c [MAX_FILTERS];
  logic [TAP_W-1:0]   tap_c [MAX_FILTERS];
  logic signed [15:0] pix_c [MAX_FILTERS];
  logic [MAX_FILTERS-1:0] done;
  logic [14:0]        res_c [MAX_FILTERS];
  logic [MAX_FILTERS-1:0] sat_c;
  logic               clr;
  assign clr = img_acc && fire;

  for (genvar f = 0; f < MAX_FILTERS; f++) begin : g_cell
    cv2_cell #(
      .IDX   (f),
      .TAPS  (TAPS),
      .TAP_W (TAP_W),
      .ACC_W (ACC_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     ((f == 0) ? feed_ctl_q : ctl_c[(f == 0) ? 0 : f-1]),
      .tap_i     ((f == 0) ? feed_tap_q : tap_c[(f == 0) ? 0 : f-1]),
      .pix_i     ((f == 0) ? line_rd_q  : pix_c[(f == 0) ? 0 : f-1]),
      .ctl_o     (ctl_c[f]),
      .tap_o     (tap_c[f]),
      .pix_o     (pix_c[f]),
      .ld_coef_i (ld_coef),
      .ld_bias_i (ld_bias),
      .ld_fsel_i (in_fsel),
      .ld_tap_i  (ld_tap),
      .ld_val_i  (in_val),
      .clr_i     (clr),
      .done_o    (done[f]),
      .res_o     (res_c[f]),
      .sat_o     (sat_c[f])
    );
  end

  // result register
  logic        ov_q, osat_q, olast_q;
  logic [14:0] oval_q;
  logic [2:0]  ofilt_q;
  logic [5:0]  orow_o_q, ocol_o_q;
  logic        out_free, out_load, oi_end;
  assign out_free = !ov_q || m_axis_tready;
  assign oi_end   = (32'(oi_q) + 1 == 32'(nf_used));
  assign out_load = (state_q == ST_DRAIN) && out_free && done[oi_q];

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oval_q   <= res_c[oi_q];
      osat_q   <= sat_c[oi_q];
      olast_q  <= oi_end;
      ofilt_q  <= 3'(oi_q);
      orow_o_q <= orow_q;
      ocol_o_q <= 6'(ocol_q);
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, ocol_o_q, orow_o_q, ofilt_q, oval_q};
  assign m_axis_tuser  = osat_q;
  assign m_axis_tlast  = olast_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      row_q      <= '0;
      col_q      <= '0;
      ch_q       <= '0;
      slot_q     <= '0;
      width_q    <= RST_WIDTH;
      height_q   <= RST_HEIGHT;
      kernel_q   <= RST_KERNEL;
      filt_q     <= RST_FILTERS;
      chans_q    <= RST_CHANNELS;
      feed_ctl_q <= '0;
      ov_q       <= 1'b0;
      oi_q       <= '0;
      q_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      rslot_q    <= '0;
      top_q      <= '0;
      orow_q     <= '0;
      ocol_q     <= '0;
    end else begin
      feed_ctl_q <= iss_ctl;

      if (out_load) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;

      if (cfg_acc) begin
        case (cfg_index_i)
          REG_WIDTH:    width_q  <= cfg_data_i;
          REG_HEIGHT:   height_q <= cfg_data_i;
          REG_KERNEL:   kernel_q <= cfg_data_i[2:0];
          REG_FILTERS:  filt_q   <= cfg_data_i[3:0];
          REG_CHANNELS: chans_q  <= cfg_data_i[2:0];
          default: ;
        endcase
        if (32'(cfg_index_i) <= 32'(REG_CHANNELS)) begin
          row_q  <= '0;
          col_q  <= '0;
          ch_q   <= '0;
          slot_q <= '0;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && in_act == ACT_SOF) begin
            row_q  <= '0;
            col_q  <= '0;
            ch_q   <= '0;
            slot_q <= '0;
          end else if (img_acc) begin
            if (fire) begin
              state_q <= ST_RUN;
              orow_q  <= 6'(32'(r_e) + 1 - 32'(k_used));
              ocol_q  <= CW'(32'(c_e) + 1 - 32'(k_used));
              if (32'(slot_e) + 1 >= 32'(k_used)) begin
                top_q   <= SW'(32'(slot_e) + 1 - 32'(k_used));
                rslot_q <= SW'(32'(slot_e) + 1 - 32'(k_used));
              end else begin
                top_q   <= SW'(32'(slot_e) + 1 + MAX_KERNEL - 32'(k_used));
                rslot_q <= SW'(32'(slot_e) + 1 + MAX_KERNEL - 32'(k_used));
              end
              q_q  <= '0;
              i_q  <= '0;
              j_q  <= '0;
              oi_q <= '0;
            end
            if (32'(ch_e) + 1 >= 32'(nc_used)) begin
              ch_q <= '0;
              if (32'(c_e) + 1 >= 32'(w_used)) begin
                col_q <= '0;
                if (32'(r_e) + 1 >= 32'(h_used)) begin
                  row_q  <= '0;
                  slot_q <= '0;
                end else begin
                  row_q  <= r_e + 6'd1;
                  slot_q <= (32'(slot_e) + 1 == MAX_KERNEL) ? '0 : SW'(32'(slot_e) + 1);
                end
              end else begin
                col_q  <= CW'(32'(c_e) + 1);
                row_q  <= r_e;
                slot_q <= slot_e;
              end
            end else begin
              ch_q   <= QW'(32'(ch_e) + 1);
              col_q  <= c_e;
              row_q  <= r_e;
              slot_q <= slot_e;
            end
          end
        end
        ST_RUN: begin
          if (j_end) begin
            j_q <= '0;
            if (i_end) begin
              i_q     <= '0;
              rslot_q <= top_q;
              if (q_end) begin
                state_q <= ST_DRAIN;
              end else begin
                q_q <= QW'(32'(q_q) + 1);
              end
            end else begin
              i_q     <= SW'(32'(i_q) + 1);
              rslot_q <= (32'(rslot_q) + 1 == MAX_KERNEL) ? '0 : SW'(32'(rslot_q) + 1);
            end
          end else begin
            j_q <= SW'(32'(j_q) + 1);
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            if (oi_end) begin
              state_q <= ST_IDLE;
            end else begin
              oi_q <= FW'(32'(oi_q) + 1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/cv2_cell.sv
// One filter cell: coefficient store, multiply, accumulate, bias, ReLU, rounding and saturation.
module cv2_cell #(
  parameter int IDX   = 0,
  parameter int TAPS  = 100,
  parameter int TAP_W = 7,
  parameter int ACC_W = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cv2_pkg::cv2_ctl_t           ctl_i,
  input  logic [TAP_W-1:0]            tap_i,
  input  logic signed [15:0]          pix_i,
  output cv2_pkg::cv2_ctl_t           ctl_o,
  output logic [TAP_W-1:0]            tap_o,
  output logic signed [15:0]          pix_o,
  input  logic                        ld_coef_i,
  input  logic                        ld_bias_i,
  input  logic [2:0]                  ld_fsel_i,
  input  logic [TAP_W-1:0]            ld_tap_i,
  input  logic signed [15:0]          ld_val_i,
  input  logic                        clr_i,
  output logic                        done_o,
  output logic [14:0]                 res_o,
  output logic                        sat_o
);
  import cv2_pkg::*;

  logic signed [VAL_W-1:0] coef_mem [TAPS];
  logic signed [VAL_W-1:0] coef_q;
  logic signed [VAL_W-1:0] pix_a_q;
  logic [TAP_W-1:0]        tap_a_q;
  cv2_ctl_t                ctl_a_q, ctl_b_q, ctl_c_q;
  logic signed [31:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, acc_rnd;
  logic signed [VAL_W-1:0] bias_q;
  logic                    done_q, sat_q;
  logic [OUT_W-1:0]        res_q;
  logic                    sel;

  assign sel = (32'(ld_fsel_i) == IDX);

  always_ff @(posedge clk_i) begin
    if (ld_coef_i && sel) begin
      coef_mem[ld_tap_i] <= ld_val_i;
    end
    coef_q  <= coef_mem[tap_i];
    pix_a_q <= pix_i;
    tap_a_q <= tap_i;
    prod_q  <= pix_a_q * coef_q;
  end

  assign ctl_o = ctl_a_q;
  assign tap_o = tap_a_q;
  assign pix_o = pix_a_q;

  always_comb begin
    if (ctl_b_q.first) begin
      acc_d = (ACC_W'(bias_q) <<< FRAC_W) + ACC_W'(prod_q);
    end else begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  assign acc_rnd = acc_q + ACC_W'(2048);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
      ctl_c_q <= '0;
      bias_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
      ctl_c_q <= ctl_b_q;
      if (ld_bias_i && sel) begin
        bias_q <= ld_val_i;
      end
      if (clr_i) begin
        done_q <= 1'b0;
      end else if (ctl_c_q.vld && ctl_c_q.last) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_b_q.vld) begin
      acc_q <= acc_d;
    end
    if (ctl_c_q.vld && ctl_c_q.last) begin
      if (acc_q[ACC_W-1] || acc_q == '0) begin
        res_q <= '0;
        sat_q <= 1'b0;
      end else if (|acc_rnd[ACC_W-1:FRAC_W+OUT_W]) begin
        res_q <= '1;
        sat_q <= 1'b1;
      end else begin
        res_q <= acc_rnd[FRAC_W+OUT_W-1:FRAC_W];
        sat_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;

endmodule

// File: sim/tb_conv2d_valid_relu_top.sv
// Self-checking testbench for the streaming 2D valid convolution / ReLU block.
module tb_conv2d_valid_relu_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cv2_pkg::*;

  localparam int NW = DEF_MAX_WIDTH;
  localparam int NK = DEF_MAX_KERNEL;
  localparam int NF = DEF_MAX_FILTERS;
  localparam int NC = DEF_MAX_CHANNELS;

  typedef struct {
    logic [14:0] value;
    logic [2:0]  filt;
    logic [5:0]  row;
    logic [5:0]  col;
    logic        sat;
    logic        lst;
  } conv_result_t;

  class conv_scoreboard;
    logic signed [15:0] pix_rows[NK*NW*NC];
    logic signed [15:0] weights[NF*NC*NK*NK];
    logic signed [15:0] biases[NF];
    int unsigned row_at, col_at, chan_at;
    int unsigned reg_w, reg_h, reg_k, reg_f, reg_c;
    conv_result_t awaited[$];
    int errors, results_seen, windows;

    function new();
      foreach (pix_rows[i]) pix_rows[i] = '0;
      foreach (weights[i]) weights[i] = '0;
      foreach (biases[i]) biases[i] = '0;
      row_at = 0; col_at = 0; chan_at = 0;
      reg_w = RST_WIDTH; reg_h = RST_HEIGHT; reg_k = RST_KERNEL;
      reg_f = RST_FILTERS; reg_c = RST_CHANNELS;
    endfunction

    function int unsigned lim(int unsigned v, int unsigned hi);
      return (v < 1) ? 1 : (v > hi) ? hi : v;
    endfunction

    function int unsigned pix_at(int unsigned r, int unsigned c, int unsigned ch);
      return ((r % NK) * NW + c) * NC + ch;
    endfunction

    function int unsigned wt_at(int unsigned f, int unsigned ch, int unsigned r,
                                int unsigned c);
      return ((f * NC + ch) * NK + r) * NK + c;
    endfunction

    function void write_reg(logic [2:0] idx, logic [6:0] d);
      case (idx)
        REG_WIDTH:    reg_w = d;
        REG_HEIGHT:   reg_h = d;
        REG_KERNEL:   reg_k = d[2:0];
        REG_FILTERS:  reg_f = d[3:0];
        REG_CHANNELS: reg_c = d[2:0];
        default: return;
      endcase
      row_at = 0; col_at = 0; chan_at = 0;
    endfunction

    function void note_item(logic [1:0] act, logic [2:0] fs, logic [1:0] cs,
                            logic [2:0] kr, logic [2:0] kc, logic signed [15:0] v);
      int unsigned w, h, k, nf, nc, r, c, ch;
      longint acc, rnd;
      conv_result_t e;
      w = lim(reg_w, NW); h = lim(reg_h, HEIGHT_LIMIT); k = lim(reg_k, NK);
      nf = lim(reg_f, NF); nc = lim(reg_c, NC);
      r = row_at; c = col_at; ch = chan_at;
      case (act)
        ACT_COEF: begin
          if (kr < NK && kc < NK) weights[wt_at(fs, cs, kr, kc)] = v;
          return;
        end
        ACT_BIAS: begin
          biases[fs] = v;
          return;
        end
        ACT_SOF: begin
          row_at = 0; col_at = 0; chan_at = 0;
          return;
        end
        default: ;
      endcase
      if (r >= h || c >= w || ch >= nc) begin
        r = 0; c = 0; ch = 0;
      end
      pix_rows[pix_at(r, c, ch)] = v;
      if (ch + 1 == nc && r + 1 >= k && c + 1 >= k) begin
        windows++;
        for (int f = 0; f < nf; f++) begin
          acc = longint'(biases[f]) * 4096;
          for (int q = 0; q < nc; q++)
            for (int i = 0; i < k; i++)
              for (int j = 0; j < k; j++)
                acc += longint'(pix_rows[pix_at(r + 1 - k + i, c + 1 - k + j, q)]) *
                       longint'(weights[wt_at(f, q, i, j)]);
          e.sat = 1'b0;
          rnd = 0;
          if (acc > 0) begin
            rnd = (acc + 2048) >>> 12;
            if (rnd > 32767) begin
              rnd = 32767; e.sat = 1'b1;
            end
          end
          e.value = rnd[14:0];
          e.filt = f[2:0];
          e.row = 6'(r + 1 - k);
          e.col = 6'(c + 1 - k);
          e.lst = (f + 1 == nf);
          awaited.insert(awaited.size(), e);
        end
      end
      ch++;
      if (ch >= nc) begin
        ch = 0; c++;
        if (c >= w) begin
          c = 0; r++;
          if (r >= h) r = 0;
        end
      end
      row_at = r; col_at = c; chan_at = ch;
    endfunction

    function void check_result(logic [31:0] d, logic sat, logic lst);
      conv_result_t e;
      results_seen++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result data=%h sat=%b last=%b", $time, d, sat, lst);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (d[14:0] !== e.value || d[17:15] !== e.filt || d[23:18] !== e.row ||
          d[29:24] !== e.col || d[31:30] !== 2'b00 || sat !== e.sat || lst !== e.lst) begin
        $display("%0t: mismatch expected val=%0d f=%0d r=%0d c=%0d sat=%b last=%b",
                 $time, e.value, e.filt, e.row, e.col, e.sat, e.lst);
        $display("%0t:          actual   val=%0d f=%0d r=%0d c=%0d sat=%b last=%b",
                 $time, d[14:0], d[17:15], d[23:18], d[29:24], sat, lst);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = ACT_SOF;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [6:0]  cfg_data_i = '0;

  conv_scoreboard sb = new();
  bit no_idle = 1'b0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int items_sent = 0;

  conv2d_valid_relu_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: check accepted transactions, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if (hold_req) begin
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && (no_idle || $urandom_range(99) >= 16);
    end
  end

  task automatic send_item(logic [1:0] act, logic [2:0] fs, logic [1:0] cs,
                           logic [2:0] kr, logic [2:0] kc, logic [15:0] v);
    s_axis_tuser <= act;
    s_axis_tdata <= {5'b0, v, kc, kr, cs, fs};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(act, fs, cs, kr, kc, v);
    items_sent++;
    if (!no_idle && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [6:0] d);
    cfg_index_i <= idx;
    cfg_data_i <= d;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, d);
  endtask

  task automatic set_shape(logic [6:0] w, logic [6:0] h, logic [6:0] k, logic [6:0] f,
                           logic [6:0] c);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_KERNEL, k);
    write_reg(REG_FILTERS, f);
    write_reg(REG_CHANNELS, c);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_val(bit full);
    return full ? 16'($urandom) : 16'($urandom_range(0, 4095) - 2048);
  endfunction

  // write bias and every weight that the current shape uses
  task automatic load_weights(bit full);
    int unsigned nf, nc, k;
    nf = sb.lim(sb.reg_f, NF);
    nc = sb.lim(sb.reg_c, NC);
    k = sb.lim(sb.reg_k, NK);
    for (int unsigned f = 0; f < nf; f++) begin
      send_item(ACT_BIAS, 3'(f), 2'd0, 3'd0, 3'd0, rand_val(full));
      for (int unsigned q = 0; q < nc; q++)
        for (int unsigned i = 0; i < k; i++)
          for (int unsigned j = 0; j < k; j++)
            send_item(ACT_COEF, 3'(f), 2'(q), 3'(i), 3'(j), rand_val(full));
    end
  endtask

  task automatic run_frame(bit full, bit with_loads);
    int unsigned n;
    n = sb.lim(sb.reg_w, NW) * sb.lim(sb.reg_h, HEIGHT_LIMIT) * sb.lim(sb.reg_c, NC);
    send_item(ACT_SOF, 3'($urandom), 2'($urandom), 3'($urandom), 3'($urandom),
              16'($urandom));
    for (int unsigned i = 0; i < n; i++) begin
      if (with_loads && $urandom_range(99) < 6)
        send_item(ACT_BIAS, 3'($urandom), 2'($urandom), 3'($urandom), 3'($urandom),
                  rand_val(full));
      if (with_loads && $urandom_range(99) < 6)
        send_item(ACT_COEF, 3'($urandom), 2'($urandom), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), rand_val(full));
      send_item(ACT_IMAGE, 3'($urandom), 2'($urandom), 3'($urandom), 3'($urandom),
                rand_val(full));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes of values, ignored load addresses, restarted frame
    set_shape(7'd4, 7'd3, 7'd2, 7'd2, 7'd2);
    load_weights(1'b1);
    send_item(ACT_BIAS, 3'd0, 2'd0, 3'd0, 3'd0, 16'h7FFF);
    send_item(ACT_BIAS, 3'd1, 2'd3, 3'd7, 3'd7, 16'h8000);
    send_item(ACT_COEF, 3'd0, 2'd0, 3'd5, 3'd0, 16'h7FFF);
    send_item(ACT_COEF, 3'd1, 2'd3, 3'd4, 3'd7, 16'h8000);
    send_item(ACT_COEF, 3'd7, 2'd3, 3'd4, 3'd4, 16'hFFFF);
    send_item(ACT_SOF, 3'd0, 2'd0, 3'd0, 3'd0, 16'h0000);
    for (int i = 0; i < 24; i++)
      send_item(ACT_IMAGE, 3'd7, 2'd3, 3'd7, 3'd7,
                (i % 3 == 0) ? 16'h7FFF : (i % 3 == 1) ? 16'h8000 : 16'h0001);
    for (int i = 0; i < 3; i++)
      send_item(ACT_IMAGE, 3'd0, 2'd0, 3'd0, 3'd0, rand_val(1'b1));
    send_item(ACT_SOF, 3'd0, 2'd0, 3'd0, 3'd0, 16'h0000);
    send_item(ACT_IMAGE, 3'd0, 2'd0, 3'd0, 3'd0, 16'h7FFF);
    send_item(ACT_IMAGE, 3'd0, 2'd0, 3'd0, 3'd0, 16'h8000);

    // lowest register values all clamp to one
    set_shape(7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
    for (int i = 0; i < 4; i++)
      send_item(ACT_IMAGE, 3'd0, 2'd0, 3'd0, 3'd0, rand_val(1'b1));

    // clamped wide row, no idling on either side
    no_idle = 1'b1;
    set_shape(7'd127, 7'd1, 7'd1, 7'd1, 7'd1);
    for (int i = 0; i < 20; i++)
      send_item(ACT_IMAGE, 3'd0, 2'd0, 3'd0, 3'd0, rand_val(1'b0));
    drain();
    no_idle = 1'b0;

    // random shapes, with a long result stall and a pause of the sender
    for (int p = 0; p < 2; p++) begin
      bit full;
      full = ($urandom_range(1) == 0);
      set_shape(7'($urandom_range(2, 3)), 7'($urandom_range(2, 3)),
                7'($urandom_range(1, 2)), 7'($urandom_range(2, 3)),
                7'($urandom_range(1, 2)));
      load_weights(full);
      if (p == 0) begin
        s_axis_tvalid <= 1'b0;
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      run_frame(full, 1'b1);
      if (p == 1) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
        run_frame(full, 1'b1);
      end
    end

    drain();
    $display("Sent %0d input transactions over directed and random frame shapes,",
             items_sent);
    $display("%0d windows, %0d results checked, %0d errors.",
             sb.windows, sb.results_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** conv2d_valid_relu_top: PASSED **");
    end else begin
      $display("** conv2d_valid_relu_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding.", sb.pending());
    $display("** conv2d_valid_relu_top: FAILED **");
    $finish;
  end

endmodule
